@@ src/skf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set filter package
// Shared widths, defaults and the control bundle handed to the key cells.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int KEY_W        = 48;
    localparam int COUNT_OUT_W  = 8;
    localparam int CAPACITY_DEF = 128;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    // Phase strobes broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // capture the compare flags against the broadcast key
        logic ins_en;   // perform the ordered insertion
    } t_cell_ctrl;

endpackage : skf_pkg
`default_nettype wire

@@ src/skf_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one slot of the ascending key array, compares it with the broadcast
// key and takes the new key or its left neighbour's key on an insertion.
// ----------------------------------------------------------------------------
module skf_cell
    import skf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cell_ctrl                    i_ctrl,
    input  wire logic [KEY_W-1:0]              i_key,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  wire logic [KEY_W-1:0]              i_left_key,
    input  wire logic                          i_left_lt,
    output logic      [KEY_W-1:0]              o_key,
    output logic                               o_lt,
    output logic                               o_eq
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] r_key;
    logic             r_lt;
    logic             r_eq;
    logic             w_valid;

    assign w_valid = (CNT_W'(INDEX) < i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_lt <= w_valid && (r_key < i_key);
            r_eq <= w_valid && (r_key == i_key);
        end
    end

    // The first slot not below the key takes the new key; every slot above it
    // takes its left neighbour's key, which moves the larger keys up by one.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && !r_lt) begin
            r_key <= i_left_lt ? i_key : i_left_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule : skf_cell
`default_nettype wire

@@ src/sorted_key_set_filter_unit.sv @@
`default_nettype none
// Timing: a command taken in idle runs the compare phase and then the update
// phase of the cell row; the result strobe is registered from the update phase
// and is raised for exactly one cycle; the receiver cannot stall it.
// Commands: busy holds off a new command until the update phase is over; a
// new start is taken during the result cycle.
// Reset: synchronous, active low; the set is empty after reset.
// ----------------------------------------------------------------------------
// Sorted key set filter unit
// Row of key cells holding an ascending set, with lookup and ordered insert.
// ----------------------------------------------------------------------------
module sorted_key_set_filter_unit
    import skf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_opcode,
    input  wire logic [KEY_W-1:0]       i_key_code,
    output logic                        o_done,
    output logic                        o_found,
    output logic                        o_inserted,
    output logic                        o_table_full,
    output logic [COUNT_OUT_W-1:0]      o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             r_found;
    logic             r_inserted;
    logic             r_full;

    t_cell_ctrl       w_ctrl;
    logic [KEY_W-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic             w_found;
    logic             w_full;
    logic             w_do_ins;
    logic             w_take;
    logic [EXT_W-1:0] w_count_ext;

    assign w_take   = start && !busy;
    assign w_found  = |w_eq;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_do_ins = (r_state == ST_UPD) && (r_op == OP_INSERT) && !w_found && !w_full;

    assign w_ctrl.cmp_en = (r_state == ST_CMP);
    assign w_ctrl.ins_en = w_do_ins;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_take) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_count = w_do_ins ? r_count + CNT_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ST_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op  <= i_opcode;
            r_key <= i_key_code;
        end
        if (r_state == ST_UPD) begin
            r_found    <= w_found;
            r_inserted <= w_do_ins;
            r_full     <= (r_op == OP_INSERT) && !w_found && w_full;
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_W-1:0] w_left_key;
            logic             w_left_lt;
            if (g == 0) begin : g_head
                assign w_left_key = r_key;
                assign w_left_lt  = 1'b1;
            end else begin : g_body
                assign w_left_key = w_cell_key[g-1];
                assign w_left_lt  = w_lt[g-1];
            end
            skf_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_key      (r_key),
                .i_count    (r_count),
                .i_left_key (w_left_key),
                .i_left_lt  (w_left_lt),
                .o_key      (w_cell_key[g]),
                .o_lt       (w_lt[g]),
                .o_eq       (w_eq[g])
            );
        end
    endgenerate

    assign w_count_ext = EXT_W'(r_count);

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_inserted    = r_inserted;
    assign o_table_full  = r_full;
    assign o_entry_count = w_count_ext[COUNT_OUT_W-1:0];

    // A transfer in starts the sequencer.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> busy)
        else $error("busy not raised after a command transfer");

    // A reported insertion grew the set by exactly one key.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inserted) |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count did not grow on insertion");

    // Found, inserted and refused are mutually exclusive.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_found, o_inserted, o_table_full}))
        else $error("conflicting result flags");

    // A refusal only happens with every slot occupied.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("insert refused while space remained");

endmodule : sorted_key_set_filter_unit
`default_nettype wire
